// ===== sv/primality_trial_division_defines.svh =====
// ----------------------------------------------------------------------------
// primality_trial_division_defines
// Assertion macros shared by the checker of the trial division block.
// ----------------------------------------------------------------------------
`ifndef PRIMALITY_TRIAL_DIVISION_DEFINES_SVH
`define PRIMALITY_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and fixed constants of the trial division primality tester.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

   // 6k +/- 1 scheme
   localparam int SIEVE_DIVISOR = 3;
   localparam int FIRST_DIVISOR = 5;
   localparam int PAIR_GAP      = 2;
   localparam int DIVISOR_STEP  = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCREEN,
      ST_DIVIDE,
      ST_EVAL,
      ST_DONE
   } ptd_state_type;

   // which divisor the shared divider is working on
   typedef enum logic [1:0] {
      PH_SIEVE,
      PH_LOW,
      PH_HIGH
   } ptd_phase_type;

endpackage

`default_nettype wire

// ===== sv/ptd_channels.sv =====
// ----------------------------------------------------------------------------
// ptd_channels
// Valid/ready channels of the trial division primality tester.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_req_if #(
   parameter int NUMBER_WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface ptd_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface

`default_nettype wire

// ===== sv/primality_trial_division.sv =====
// ----------------------------------------------------------------------------
// primality_trial_division
// Trial division primality test over the 6k +/- 1 divisor sequence.
// ----------------------------------------------------------------------------
// Accepts one unsigned candidate and answers with one item whose prime_flag
// is 1 when the candidate is prime. Values below 2 are not prime, 2 and 3
// are, even values are rejected at once, then divisors 3, 5, 7, 11, 13, ...
// (pairs i, i+2 with i = 5 + 6k) are tried while i <= candidate / i. All
// division goes through one shared restoring divider that retires one
// quotient bit a cycle, so each trial divisor costs NUMBER_WIDTH divide
// steps and one evaluation step. An item that is screened out early goes
// from ST_SCREEN straight to ST_DONE. The block holds one item at a time:
// req_chan.ready is high only while idle, and the result is held until
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module primality_trial_division #(
   parameter int NUMBER_WIDTH = 32
) (
   input  wire        clock,
   input  wire        reset,
   ptd_req_if.sink    req_chan,
   ptd_rsp_if.source  rsp_chan
);
   import ptd_pkg::*;

   localparam int W     = NUMBER_WIDTH;
   localparam int CNT_W = $clog2(W);

   ptd_state_type state_ff, state_in;
   ptd_phase_type phase_ff, phase_in;

   logic [W-1:0]     num_ff, num_in;
   logic [W-1:0]     base_ff, base_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             flag_ff, flag_in;

   logic         in_valid, in_ready, out_valid, out_ready, out_flag;
   logic [W-1:0] in_candidate;

   logic [W:0]   trial;
   logic [W:0]   diff;
   logic         take;
   logic [W-1:0] step_rem, step_quo;
   logic         div_last, rem_zero, below_two, up_to_three, past_root;
   logic [W-1:0] pair_hi, next_base;

   assign in_valid     = req_chan.valid;
   assign in_candidate = req_chan.candidate;
   assign out_ready    = rsp_chan.ready;
   assign req_chan.ready      = in_ready;
   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.prime_flag = out_flag;

   // shared divider: one restoring step per cycle
   assign trial    = {rem_ff, quo_ff[W-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign take     = (trial >= {1'b0, dvs_ff});
   assign step_rem = take ? diff[W-1:0] : trial[W-1:0];
   assign step_quo = {quo_ff[W-2:0], take};
   assign div_last = (cnt_ff == CNT_W'(W - 1));

   assign rem_zero    = (rem_ff == '0);
   assign below_two   = (num_ff <= W'(1));
   assign up_to_three = (num_ff <= W'(SIEVE_DIVISOR));
   assign past_root   = (base_ff > quo_ff);
   assign pair_hi     = base_ff + W'(PAIR_GAP);
   assign next_base   = base_ff + W'(DIVISOR_STEP);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_SCREEN;
         end
         ST_SCREEN: begin
            if (below_two || up_to_three || !num_ff[0]) state_in = ST_DONE;
            else state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (phase_ff)
               PH_SIEVE: state_in = rem_zero ? ST_DONE : ST_DIVIDE;
               PH_LOW:   state_in = (past_root || rem_zero) ? ST_DONE : ST_DIVIDE;
               PH_HIGH:  state_in = rem_zero ? ST_DONE : ST_DIVIDE;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      in_ready  = (state_ff == ST_IDLE);
      out_valid = (state_ff == ST_DONE);
      out_flag  = flag_ff;
      num_in    = num_ff;
      base_in   = base_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      flag_in   = flag_ff;
      phase_in  = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            num_in = in_candidate;
         end
         ST_SCREEN: begin
            flag_in  = !below_two && up_to_three;
            dvs_in   = W'(SIEVE_DIVISOR);
            phase_in = PH_SIEVE;
            rem_in   = '0;
            quo_in   = num_ff;
            cnt_in   = '0;
         end
         ST_DIVIDE: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_EVAL: begin
            rem_in  = '0;
            quo_in  = num_ff;
            cnt_in  = '0;
            flag_in = 1'b0;
            case (phase_ff)
               PH_SIEVE: begin
                  base_in  = W'(FIRST_DIVISOR);
                  dvs_in   = W'(FIRST_DIVISOR);
                  phase_in = PH_LOW;
               end
               PH_LOW: begin
                  // divisor beyond the square root: no factor left
                  flag_in  = past_root;
                  dvs_in   = pair_hi;
                  phase_in = PH_HIGH;
               end
               PH_HIGH: begin
                  base_in  = next_base;
                  dvs_in   = next_base;
                  phase_in = PH_LOW;
               end
               default: begin
                  phase_in = PH_SIEVE;
               end
            endcase
         end
         ST_DONE: begin
            // hold the result until taken
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      base_ff  <= base_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      flag_ff  <= flag_in;
      phase_ff <= phase_in;
   end

endmodule

`default_nettype wire

// ===== sv/ptd_checker.sv =====
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the trial division primality tester.
// ----------------------------------------------------------------------------
`default_nettype none

`include "primality_trial_division_defines.svh"

module ptd_checker #(
   parameter int NUMBER_WIDTH = 32
) (
   input wire                    clock,
   input wire                    reset,
   input wire                    in_valid,
   input wire                    in_ready,
   input wire [NUMBER_WIDTH-1:0] in_candidate,
   input wire                    out_valid,
   input wire                    out_ready,
   input wire                    out_flag
);
   import ptd_pkg::*;

   logic in_fire;
   logic stalled;
   logic small_prime;

   assign in_fire     = in_valid && in_ready;
   assign stalled     = out_valid && !out_ready;
   assign small_prime = (in_candidate == NUMBER_WIDTH'(PAIR_GAP)) ||
                        (in_candidate == NUMBER_WIDTH'(SIEVE_DIVISOR));

   `PTD_ASSERT_NEXT(a_hold_result, clock, reset, stalled, out_valid && $stable(out_flag), "result dropped or changed while stalled")
   `PTD_ASSERT_NOW(a_one_item, clock, reset, out_valid, !in_ready, "new item taken while a result waits")
   `PTD_ASSERT_NEXT(a_no_instant_result, clock, reset, in_fire, !out_valid, "result shown right after an item was taken")
   `PTD_ASSERT_NOW(a_small_prime, clock, reset, in_fire && small_prime, ##2 (out_valid && out_flag), "two or three not reported prime in time")

endmodule

bind primality_trial_division ptd_checker #(
   .NUMBER_WIDTH (NUMBER_WIDTH)
) u_ptd_checker (
   .clock        (clock),
   .reset        (reset),
   .in_valid     (in_valid),
   .in_ready     (in_ready),
   .in_candidate (in_candidate),
   .out_valid    (out_valid),
   .out_ready    (out_ready),
   .out_flag     (out_flag)
);

`default_nettype wire

// ===== test/primality_trial_division_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// primality_trial_division_test
// Self-checking bench for the trial division primality tester.
// ----------------------------------------------------------------------------
// Feeds candidates through the request channel and checks every answer
// against a local 6k +/- 1 trial division. A short directed set covers the
// small values, squares of the trial divisors, full-width words and the
// largest 32-bit prime. A long result stall follows, then random candidates
// under three idling patterns. Most random values are small, and large ones
// carry a small factor, so the run stays short.
// ----------------------------------------------------------------------------

module primality_trial_division_test;
   import ptd_pkg::*;

   localparam int NUMBER_WIDTH  = 32;
   localparam int RESET_CYCLES  = 7;
   localparam int LONG_HOLD     = 300;
   localparam int TAIL_CYCLES   = 100;
   localparam int RANDOM_ITEMS  = 65;

   typedef enum {
      FLOW_RECEIVER_SLOW,
      FLOW_SENDER_SLOW,
      FLOW_FULL_RATE
   } flow_mode_type;

   typedef struct {
      logic [NUMBER_WIDTH-1:0] candidate;
      bit                      prime_flag;
   } verdict_type;

   logic clock = 1'b0;
   logic reset;

   ptd_req_if #(.NUMBER_WIDTH(NUMBER_WIDTH)) req_chan ();
   ptd_rsp_if                                rsp_chan ();

   primality_trial_division #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [NUMBER_WIDTH-1:0] pending_candidates[$];
   verdict_type             due_verdicts[$];
   flow_mode_type           flow_mode = FLOW_FULL_RATE;
   bit                      req_taken = 1'b0;
   bit                      hold_go = 1'b0;
   bit                      rsp_holding = 1'b0;
   int                      error_count = 0;
   int                      items_accepted = 0;
   int                      results_checked = 0;
   int                      primes_seen = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // 6k +/- 1 trial division at 64 bits, so the bound test cannot wrap
   function automatic bit candidate_is_prime(logic [NUMBER_WIDTH-1:0] value);
      longint unsigned n;
      longint unsigned d;
      n = value;
      if (n <= 1) return 1'b0;
      if (n <= SIEVE_DIVISOR) return 1'b1;
      if (n % 2 == 0 || n % SIEVE_DIVISOR == 0) return 1'b0;
      for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
         if (n % d == 0 || n % (d + PAIR_GAP) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // keep large values cheap: give them a factor of at most 200
   function automatic logic [NUMBER_WIDTH-1:0] random_candidate();
      int unsigned             pick;
      int unsigned             factor;
      logic [NUMBER_WIDTH-1:0] raw;
      pick   = $urandom_range(0, 99);
      raw    = $urandom;
      factor = $urandom_range(2, 200);
      if (pick < 10) return $urandom_range(0, 15);
      if (pick < 55) return $urandom_range(0, 65535);
      if (pick < 70) return $urandom_range(65536, 1048575);
      return (raw / factor) * factor;
   endfunction

   function automatic bit sender_idles();
      case (flow_mode)
         FLOW_RECEIVER_SLOW: return $urandom_range(0, 99) < 6;
         FLOW_SENDER_SLOW:   return $urandom_range(0, 99) < 88;
         default:            return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_idles();
      case (flow_mode)
         FLOW_RECEIVER_SLOW: return $urandom_range(0, 99) < 88;
         FLOW_SENDER_SLOW:   return $urandom_range(0, 99) < 6;
         default:            return 1'b0;
      endcase
   endfunction

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.candidate = '0;
      rsp_chan.ready     = 1'b0;
   end

   // request driver: hold the item until taken, then offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_candidates.size() != 0 && !sender_idles()) begin
            req_chan.valid     <= 1'b1;
            req_chan.candidate <= pending_candidates.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_holding) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !receiver_idles();
      end
   end

   // long result stall, counted on its own
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_holding = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_holding = 1'b0;
   end

   always @(posedge clock) begin : watch_channels
      verdict_type due;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_verdicts.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual prime_flag %0b",
                        $time, rsp_chan.prime_flag);
               error_count++;
            end else begin
               due = due_verdicts.pop_front();
               results_checked++;
               if (rsp_chan.prime_flag !== due.prime_flag) begin
                  $display("%0t: prime_flag for %0d: expected %0b, actual %0b",
                           $time, due.candidate, due.prime_flag, rsp_chan.prime_flag);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            due.candidate  = req_chan.candidate;
            due.prime_flag = candidate_is_prime(req_chan.candidate);
            due_verdicts.push_back(due);
            items_accepted++;
            if (due.prime_flag) primes_seen++;
         end
      end
   end

   initial begin
      logic [NUMBER_WIDTH-1:0] directed[$];
      int                      phase_items;
      directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 35, 49, 121, 143, 169,
                   1018081, 1052651, 65521, 65537, 32'h8000_0000,
                   32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4294967291};
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      flow_mode = FLOW_RECEIVER_SLOW;
      foreach (directed[k]) pending_candidates.push_back(directed[k]);

      // wait until every answer is back
      while (pending_candidates.size() != 0 || req_chan.valid || due_verdicts.size() != 0)
         @(posedge clock);

      // stall results while the sender keeps offering
      flow_mode = FLOW_FULL_RATE;
      hold_go   = 1'b1;
      repeat (10) pending_candidates.push_back($urandom_range(0, 255));
      while (pending_candidates.size() != 0) @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         flow_mode   = phase == 0 ? FLOW_RECEIVER_SLOW :
                       phase == 1 ? FLOW_SENDER_SLOW : FLOW_FULL_RATE;
         phase_items = phase == 0 ? RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) : RANDOM_ITEMS / 3;
         repeat (phase_items) pending_candidates.push_back(random_candidate());
         while (pending_candidates.size() != 0) @(posedge clock);
      end

      while (req_chan.valid || due_verdicts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Tested %0d candidates (%0d prime) and checked %0d answers,",
               items_accepted, primes_seen, results_checked);
      $display("with a long result stall and three idling patterns.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ptd_pkg.sv
sv/ptd_channels.sv
sv/primality_trial_division.sv
sv/ptd_checker.sv
test/primality_trial_division_test.sv
